// ===== hdl/bc_pkg.sv =====
package bc_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TSTART,
        S_T_X1,
        S_T_B5,
        S_PSTART,
        S_P_SQ,
        S_P_X1,
        S_P_X2,
        S_P_X1B,
        S_P_X3,
        S_P_B4,
        S_P_B7,
        S_P_P,
        S_P_QQ,
        S_P_X1C,
        S_P_FIN,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    localparam logic [2:0] C_REG_CAL_A = 3'd0;
    localparam logic [2:0] C_REG_CAL_B = 3'd1;
    localparam logic [2:0] C_REG_CAL_C = 3'd2;
    localparam logic [2:0] C_REG_MD    = 3'd3;
    localparam logic [2:0] C_REG_OSS   = 3'd4;

    localparam logic       C_KIND_TEMP = 1'b0;

    localparam logic [5:0] C_MUL_LAST = 6'd31;
    localparam logic [5:0] C_DIV_LAST = 6'd33;

    localparam logic signed [63:0] C_B6_OFFSET  = 64'sd4000;
    localparam logic signed [63:0] C_B4_OFFSET  = 64'sd32768;
    localparam logic [15:0]        C_B7_SCALE   = 16'd50000;
    localparam logic signed [31:0] C_P_SQ_COEF  = 32'sd3038;
    localparam logic signed [31:0] C_P_LIN_COEF = -32'sd7357;
    localparam logic signed [63:0] C_P_OFFSET   = 64'sd3791;
    localparam logic signed [63:0] C_T_ROUND    = 64'sd8;

    localparam logic signed [63:0] C_TEMP_MAX = 64'sd32767;
    localparam logic signed [63:0] C_TEMP_MIN = -64'sd32768;
    localparam logic signed [63:0] C_PRES_MAX = 64'sd262143;

    // Signed division by two to the power k, truncating toward zero.
    function automatic logic signed [63:0] f_tdiv(input logic signed [63:0] v,
                                                  input int unsigned k);
        logic signed [63:0] bias;
        bias = (64'sd1 <<< k) - 64'sd1;
        return (v < 0) ? ((v + bias) >>> k) : (v >>> k);
    endfunction

endpackage

// ===== hdl/barometer_compensation.sv =====
// Compensates raw barometric sensor readings with the usual integer algorithm. Each request
// carries a kind (0 temperature, 1 pressure) and a raw reading; it yields one result with
// temperature in 0.1 degree C, pressure in pascals and a divide error flag. A temperature
// request without a divide error also updates the kept b5 value used by later pressure
// requests. All arithmetic goes through one shift-and-add multiplier and one restoring
// divider; a zero divisor ends a request early with the divide error flag set. The input
// is stalled from acceptance until the result has been taken. The user must write
// calibration through the configuration port only while the block is idle; the block
// itself does not enforce this.
module barometer_compensation (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [47:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_kind,
    input  logic [23:0]         i_raw_reading,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_result_kind,
    output logic signed [15:0]  o_temperature,
    output logic [17:0]         o_pressure,
    output logic                o_divide_error
);

    bc_pkg::t_state r_state, n_state, r_ret, n_ret;

    logic [47:0] r_cal_a, r_cal_b, r_cal_c;
    logic [15:0] r_cal_md;
    logic [1:0]  r_oss;
    logic signed [31:0] r_b5, n_b5;

    logic signed [63:0] r_ma, n_ma, r_macc, n_macc;
    logic signed [31:0] r_mb, n_mb;
    logic [5:0]  r_cnt, n_cnt;
    logic [33:0] r_dq, n_dq;
    logic [31:0] r_dd, n_dd, r_dr, n_dr;
    logic        r_neg, n_neg, r_dbl, n_dbl;

    logic        r_kind, n_kind, r_err, n_err;
    logic [23:0] r_raw, n_raw, r_up, n_up;
    logic signed [31:0] r_b6, n_b6, r_q, n_q;
    logic signed [45:0] r_sq, n_sq;
    logic signed [63:0] r_x1, n_x1, r_b3, n_b3;
    logic [16:0] r_b4, n_b4;
    logic signed [35:0] r_p, n_p;
    logic signed [15:0] r_temp, n_temp;
    logic [17:0] r_pres, n_pres;

    logic signed [63:0] w_ac1, w_ac2, w_ac3, w_b1, w_b2, w_mc, w_md;
    logic [15:0] w_ac4, w_ac5, w_ac6;
    logic signed [63:0] w_den;
    logic        w_den_zero, w_b4_zero, w_accept;

    assign w_ac1 = 64'(signed'(r_cal_a[15:0]));
    assign w_ac2 = 64'(signed'(r_cal_a[31:16]));
    assign w_ac3 = 64'(signed'(r_cal_a[47:32]));
    assign w_ac4 = r_cal_b[15:0];
    assign w_ac5 = r_cal_b[31:16];
    assign w_ac6 = r_cal_b[47:32];
    assign w_b1  = 64'(signed'(r_cal_c[15:0]));
    assign w_b2  = 64'(signed'(r_cal_c[31:16]));
    assign w_mc  = 64'(signed'(r_cal_c[47:32]));
    assign w_md  = 64'(signed'(r_cal_md));

    assign w_den      = bc_pkg::f_tdiv(r_macc, 15) + w_md;
    assign w_den_zero = (w_den == 64'sd0);
    assign w_b4_zero  = (r_macc[31:15] == 17'd0);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        o_in_stall     = (r_state != bc_pkg::S_IDLE);
        o_out_valid    = (r_state == bc_pkg::S_OUT);
        o_result_kind  = r_kind;
        o_temperature  = r_temp;
        o_pressure     = r_pres;
        o_divide_error = r_err;
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            bc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_kind == bc_pkg::C_KIND_TEMP) ? bc_pkg::S_TSTART
                                                              : bc_pkg::S_PSTART;
                end
            end
            bc_pkg::S_TSTART: begin
                n_state = bc_pkg::S_MUL;
                n_ret   = bc_pkg::S_T_X1;
            end
            bc_pkg::S_T_X1: begin
                if (w_den_zero) begin
                    n_state = bc_pkg::S_OUT;
                end else begin
                    n_state = bc_pkg::S_DIV;
                    n_ret   = bc_pkg::S_T_B5;
                end
            end
            bc_pkg::S_T_B5:   n_state = bc_pkg::S_OUT;
            bc_pkg::S_PSTART: begin
                n_state = bc_pkg::S_MUL;
                n_ret   = bc_pkg::S_P_SQ;
            end
            bc_pkg::S_P_SQ: begin
                n_state = bc_pkg::S_MUL;
                n_ret   = bc_pkg::S_P_X1;
            end
            bc_pkg::S_P_X1: begin
                n_state = bc_pkg::S_MUL;
                n_ret   = bc_pkg::S_P_X2;
            end
            bc_pkg::S_P_X2: begin
                n_state = bc_pkg::S_MUL;
                n_ret   = bc_pkg::S_P_X1B;
            end
            bc_pkg::S_P_X1B: begin
                n_state = bc_pkg::S_MUL;
                n_ret   = bc_pkg::S_P_X3;
            end
            bc_pkg::S_P_X3: begin
                n_state = bc_pkg::S_MUL;
                n_ret   = bc_pkg::S_P_B4;
            end
            bc_pkg::S_P_B4: begin
                if (w_b4_zero) begin
                    n_state = bc_pkg::S_OUT;
                end else begin
                    n_state = bc_pkg::S_MUL;
                    n_ret   = bc_pkg::S_P_B7;
                end
            end
            bc_pkg::S_P_B7: begin
                n_state = bc_pkg::S_DIV;
                n_ret   = bc_pkg::S_P_P;
            end
            bc_pkg::S_P_P: begin
                n_state = bc_pkg::S_MUL;
                n_ret   = bc_pkg::S_P_QQ;
            end
            bc_pkg::S_P_QQ: begin
                n_state = bc_pkg::S_MUL;
                n_ret   = bc_pkg::S_P_X1C;
            end
            bc_pkg::S_P_X1C: begin
                n_state = bc_pkg::S_MUL;
                n_ret   = bc_pkg::S_P_FIN;
            end
            bc_pkg::S_P_FIN: n_state = bc_pkg::S_OUT;
            bc_pkg::S_MUL: begin
                if (r_cnt == bc_pkg::C_MUL_LAST) begin
                    n_state = r_ret;
                end
            end
            bc_pkg::S_DIV: begin
                if (r_cnt == bc_pkg::C_DIV_LAST) begin
                    n_state = r_ret;
                end
            end
            bc_pkg::S_OUT: begin
                if (!i_out_stall) begin
                    n_state = bc_pkg::S_IDLE;
                end
            end
            default: n_state = bc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        logic signed [63:0] v_add, v_t, v_mag, v_x2, v_x3, v_u;
        logic [32:0]        v_rem;
        logic [31:0]        v_w;
        logic               v_bit;

        n_ma = r_ma;  n_mb = r_mb;  n_macc = r_macc;  n_cnt = r_cnt;
        n_dq = r_dq;  n_dd = r_dd;  n_dr = r_dr;  n_neg = r_neg;  n_dbl = r_dbl;
        n_kind = r_kind;  n_err = r_err;  n_raw = r_raw;  n_up = r_up;
        n_b6 = r_b6;  n_q = r_q;  n_sq = r_sq;  n_x1 = r_x1;  n_b3 = r_b3;
        n_b4 = r_b4;  n_p = r_p;  n_temp = r_temp;  n_pres = r_pres;  n_b5 = r_b5;
        v_add = '0;  v_t = '0;  v_mag = '0;  v_x2 = '0;  v_x3 = '0;  v_u = '0;
        v_rem = '0;  v_w = '0;  v_bit = 1'b0;

        case (r_state)
            bc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_kind = i_kind;
                    n_raw  = i_raw_reading;
                    n_err  = 1'b0;
                    n_temp = '0;
                    n_pres = '0;
                end
            end
            bc_pkg::S_TSTART: begin
                n_ma   = 64'(signed'({1'b0, r_raw[15:0]})) - 64'(signed'({1'b0, w_ac6}));
                n_mb   = 32'(signed'({1'b0, w_ac5}));
                n_macc = '0;
                n_cnt  = '0;
            end
            bc_pkg::S_T_X1: begin
                n_x1 = bc_pkg::f_tdiv(r_macc, 15);
                if (w_den_zero) begin
                    n_err = 1'b1;
                end else begin
                    v_mag = (w_mc < 0) ? -w_mc : w_mc;
                    n_dq  = 34'(v_mag <<< 11);
                    v_t   = (w_den < 0) ? -w_den : w_den;
                    n_dd  = v_t[31:0];
                    n_dr  = '0;
                    n_cnt = '0;
                    n_neg = w_mc[63] ^ w_den[63];
                end
            end
            bc_pkg::S_T_B5: begin
                v_t    = r_neg ? -64'(signed'({1'b0, r_dq})) : 64'(signed'({1'b0, r_dq}));
                v_t    = r_x1 + v_t;
                n_b5   = 32'(v_t);
                v_t    = bc_pkg::f_tdiv(v_t + bc_pkg::C_T_ROUND, 4);
                if (v_t > bc_pkg::C_TEMP_MAX) begin
                    v_t = bc_pkg::C_TEMP_MAX;
                end else if (v_t < bc_pkg::C_TEMP_MIN) begin
                    v_t = bc_pkg::C_TEMP_MIN;
                end
                n_temp = 16'(v_t);
            end
            bc_pkg::S_PSTART: begin
                n_up   = 24'(r_raw >> (4'd8 - {2'b00, r_oss}));
                v_t    = 64'(r_b5) - bc_pkg::C_B6_OFFSET;
                n_b6   = 32'(v_t);
                n_ma   = v_t;
                n_mb   = 32'(v_t);
                n_macc = '0;
                n_cnt  = '0;
            end
            bc_pkg::S_P_SQ: begin
                v_t    = bc_pkg::f_tdiv(r_macc, 12);
                n_sq   = 46'(v_t);
                n_ma   = v_t;
                n_mb   = 32'(w_b2);
                n_macc = '0;
                n_cnt  = '0;
            end
            bc_pkg::S_P_X1: begin
                n_x1   = bc_pkg::f_tdiv(r_macc, 11);
                n_ma   = 64'(r_b6);
                n_mb   = 32'(w_ac2);
                n_macc = '0;
                n_cnt  = '0;
            end
            bc_pkg::S_P_X2: begin
                v_x3   = r_x1 + bc_pkg::f_tdiv(r_macc, 11);
                v_t    = ((w_ac1 <<< 2) + v_x3) <<< r_oss;
                n_b3   = bc_pkg::f_tdiv(v_t + 64'sd2, 2);
                n_ma   = 64'(r_b6);
                n_mb   = 32'(w_ac3);
                n_macc = '0;
                n_cnt  = '0;
            end
            bc_pkg::S_P_X1B: begin
                n_x1   = bc_pkg::f_tdiv(r_macc, 13);
                n_ma   = 64'(r_sq);
                n_mb   = 32'(w_b1);
                n_macc = '0;
                n_cnt  = '0;
            end
            bc_pkg::S_P_X3: begin
                v_x3   = bc_pkg::f_tdiv(r_x1 + bc_pkg::f_tdiv(r_macc, 16) + 64'sd2, 2);
                v_u    = v_x3 + bc_pkg::C_B4_OFFSET;
                n_ma   = 64'(signed'({32'd0, v_u[31:0]}));
                n_mb   = 32'(signed'({1'b0, w_ac4}));
                n_macc = '0;
                n_cnt  = '0;
            end
            bc_pkg::S_P_B4: begin
                if (w_b4_zero) begin
                    n_err = 1'b1;
                end else begin
                    n_b4   = r_macc[31:15];
                    v_u    = 64'(signed'({40'd0, r_up})) - r_b3;
                    n_ma   = 64'(signed'({32'd0, v_u[31:0]}));
                    n_mb   = 32'(signed'({16'd0, 16'(bc_pkg::C_B7_SCALE >> r_oss)}));
                    n_macc = '0;
                    n_cnt  = '0;
                end
            end
            bc_pkg::S_P_B7: begin
                v_w   = r_macc[31:0];
                n_dbl = v_w[31];
                n_dq  = v_w[31] ? {2'b00, v_w} : {1'b0, v_w, 1'b0};
                n_dd  = {15'd0, r_b4};
                n_dr  = '0;
                n_cnt = '0;
            end
            bc_pkg::S_P_P: begin
                v_t    = r_dbl ? 64'(signed'({1'b0, r_dq, 1'b0}))
                               : 64'(signed'({2'b00, r_dq}));
                n_p    = 36'(v_t);
                v_u    = v_t >>> 8;
                n_q    = 32'(v_u);
                n_ma   = v_u;
                n_mb   = bc_pkg::C_P_SQ_COEF;
                n_macc = '0;
                n_cnt  = '0;
            end
            bc_pkg::S_P_QQ: begin
                n_ma   = r_macc;
                n_mb   = r_q;
                n_macc = '0;
                n_cnt  = '0;
            end
            bc_pkg::S_P_X1C: begin
                n_x1   = bc_pkg::f_tdiv(r_macc, 16);
                n_ma   = 64'(r_p);
                n_mb   = bc_pkg::C_P_LIN_COEF;
                n_macc = '0;
                n_cnt  = '0;
            end
            bc_pkg::S_P_FIN: begin
                v_x2 = bc_pkg::f_tdiv(r_macc, 16);
                v_t  = 64'(r_p) + bc_pkg::f_tdiv(r_x1 + v_x2 + bc_pkg::C_P_OFFSET, 4);
                if (v_t < 0) begin
                    v_t = '0;
                end else if (v_t > bc_pkg::C_PRES_MAX) begin
                    v_t = bc_pkg::C_PRES_MAX;
                end
                n_pres = v_t[17:0];
            end
            bc_pkg::S_MUL: begin
                if (r_mb[0]) begin
                    v_add = (r_cnt == bc_pkg::C_MUL_LAST) ? -r_ma : r_ma;
                end
                n_macc = r_macc + v_add;
                n_ma   = r_ma <<< 1;
                n_mb   = r_mb >>> 1;
                n_cnt  = r_cnt + 6'd1;
            end
            bc_pkg::S_DIV: begin
                v_rem = {r_dr, r_dq[33]};
                v_bit = (v_rem >= {1'b0, r_dd});
                n_dr  = v_bit ? 32'(v_rem - {1'b0, r_dd}) : v_rem[31:0];
                n_dq  = {r_dq[32:0], v_bit};
                n_cnt = r_cnt + 6'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bc_pkg::S_IDLE;
            r_ret    <= bc_pkg::S_IDLE;
            r_cal_a  <= '0;
            r_cal_b  <= '0;
            r_cal_c  <= '0;
            r_cal_md <= '0;
            r_oss    <= 2'd3;
            r_b5     <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_b5    <= n_b5;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bc_pkg::C_REG_CAL_A: r_cal_a  <= i_cfg_data;
                    bc_pkg::C_REG_CAL_B: r_cal_b  <= i_cfg_data;
                    bc_pkg::C_REG_CAL_C: r_cal_c  <= i_cfg_data;
                    bc_pkg::C_REG_MD:    r_cal_md <= i_cfg_data[15:0];
                    bc_pkg::C_REG_OSS:   r_oss    <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_macc <= n_macc;
        r_cnt  <= n_cnt;
        r_dq   <= n_dq;
        r_dd   <= n_dd;
        r_dr   <= n_dr;
        r_neg  <= n_neg;
        r_dbl  <= n_dbl;
        r_kind <= n_kind;
        r_err  <= n_err;
        r_raw  <= n_raw;
        r_up   <= n_up;
        r_b6   <= n_b6;
        r_q    <= n_q;
        r_sq   <= n_sq;
        r_x1   <= n_x1;
        r_b3   <= n_b3;
        r_b4   <= n_b4;
        r_p    <= n_p;
        r_temp <= n_temp;
        r_pres <= n_pres;
    end

    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("result offered while input not stalled");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> !o_out_valid)
        else $error("result repeated");

    a_error_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_divide_error) |-> (o_temperature == 16'sd0 && o_pressure == 18'd0))
        else $error("divide error with non-zero result");

    a_temp_no_pres: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_result_kind) |-> (o_pressure == 18'd0))
        else $error("temperature result carries pressure");

endmodule
